// ===== rtl/bmpdec_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpdec_pkg
// Shared types and constants for the 32-bit BMP to RGB565 decoder.
// ----------------------------------------------------------------------------
package bmpdec_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 512;
   localparam int MAX_HEIGHT_DEFAULT = 512;

   localparam int          HEADER_BYTES = 54;
   localparam logic [15:0] SIGNATURE    = 16'h4D42;
   localparam logic [31:0] INFO_SIZE    = 32'd40;
   localparam logic [15:0] BIT_COUNT    = 16'd32;

   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_SIGNATURE   = 3'd1;
   localparam logic [2:0] ERR_INFO_SIZE   = 3'd2;
   localparam logic [2:0] ERR_DEPTH       = 3'd3;
   localparam logic [2:0] ERR_COMPRESSION = 3'd4;
   localparam logic [2:0] ERR_TOO_LARGE   = 3'd5;
   localparam logic [2:0] ERR_TRUNCATED   = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [17:0] pixel_address;
      logic [15:0] pixel_value;
      logic [9:0]  image_width;
      logic [9:0]  image_height;
      logic [2:0]  error_code;
      logic        is_last;
   } rsp_word_type;

endpackage

// ===== rtl/bmp_to_rgb565_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// bmp_to_rgb565_decoder_unit
// Streams a 32-bit uncompressed BMP file and produces RGB565 frame writes.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle, sustained, and answers in the cycle after
// the byte is taken. The 54-byte header is checked on its last byte, which
// yields a header word (width, absolute height) or an error word. Bytes up to
// the pixel offset are dropped; every fourth pixel byte yields a pixel write
// whose address flips bottom-up rows. The only limit on rate is the single
// result register: while it holds a word and rsp_stall is high, req_stall is
// high. After an error or the end of the image, bytes are dropped until the
// byte marked end_of_file, which returns the block to its reset state.
// ----------------------------------------------------------------------------
module bmp_to_rgb565_decoder_unit #(
   parameter int MAX_WIDTH  = bmpdec_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = bmpdec_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  bmpdec_pkg::req_word_type req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output bmpdec_pkg::rsp_word_type rsp_word
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int SW = (CW + RW + 1 > 18) ? (CW + RW + 1) : 18;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_SKIP   = 3'd1;
   localparam logic [2:0] PH_PIXELS = 3'd2;
   localparam logic [2:0] PH_DONE   = 3'd3;
   localparam logic [2:0] PH_ERROR  = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] byte_count_ff, byte_count_in;
   logic [15:0] sig_ff, sig_in;
   logic [15:0] bpp_ff, bpp_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] info_ff, info_in;
   logic [31:0] width_raw_ff, width_raw_in;
   logic [31:0] height_raw_ff, height_raw_in;
   logic [31:0] compress_ff, compress_in;
   logic [CW-1:0] width_ff, width_in;
   logic [RW-1:0] height_ff, height_in;
   logic [CW-1:0] column_ff, column_in;
   logic [RW-1:0] row_ff, row_in;
   logic [1:0]  channel_ff, channel_in;
   logic [4:0]  blue_ff, blue_in;
   logic [5:0]  green_ff, green_in;
   logic [4:0]  red_ff, red_in;
   logic        bottom_up_ff, bottom_up_in;
   logic        rsp_valid_ff, rsp_valid_in;
   bmpdec_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic        accept;
   logic [5:0]  pos;
   logic [1:0]  lane;
   logic [31:0] abs_height;
   logic [2:0]  check_code;
   logic        err_out;
   logic        fire;
   bmpdec_pkg::rsp_word_type out_word;
   logic [RW-1:0] mem_row;
   logic [SW-1:0] addr_full;
   logic [CW:0]   column_next;
   logic [RW:0]   row_next;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign pos  = byte_count_ff[5:0];
   assign abs_height = height_raw_ff[31] ? (32'd0 - height_raw_ff) : height_raw_ff;

   always_comb begin
      if (sig_ff != bmpdec_pkg::SIGNATURE) begin
         check_code = bmpdec_pkg::ERR_SIGNATURE;
      end else if (info_ff != bmpdec_pkg::INFO_SIZE) begin
         check_code = bmpdec_pkg::ERR_INFO_SIZE;
      end else if (bpp_ff != bmpdec_pkg::BIT_COUNT) begin
         check_code = bmpdec_pkg::ERR_DEPTH;
      end else if (compress_ff != 32'd0) begin
         check_code = bmpdec_pkg::ERR_COMPRESSION;
      end else if (width_raw_ff[31] || (width_raw_ff > 32'(MAX_WIDTH))) begin
         check_code = bmpdec_pkg::ERR_TOO_LARGE;
      end else if (abs_height > 32'(MAX_HEIGHT)) begin
         check_code = bmpdec_pkg::ERR_TOO_LARGE;
      end else if (offset_ff < 32'(bmpdec_pkg::HEADER_BYTES)) begin
         check_code = bmpdec_pkg::ERR_TRUNCATED;
      end else begin
         check_code = bmpdec_pkg::ERR_NONE;
      end
   end

   assign mem_row     = bottom_up_ff ? (height_ff - RW'(1) - row_ff) : row_ff;
   assign addr_full   = SW'(column_ff) + SW'(width_ff) * SW'(mem_row);
   assign column_next = {1'b0, column_ff} + (CW+1)'(1);
   assign row_next    = {1'b0, row_ff} + (RW+1)'(1);

   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      sig_in        = sig_ff;
      bpp_in        = bpp_ff;
      offset_in     = offset_ff;
      info_in       = info_ff;
      width_raw_in  = width_raw_ff;
      height_raw_in = height_raw_ff;
      compress_in   = compress_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      channel_in    = channel_ff;
      blue_in       = blue_ff;
      green_in      = green_ff;
      red_in        = red_ff;
      bottom_up_in  = bottom_up_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_word_in   = rsp_word_ff;
      out_word      = '0;
      fire          = 1'b0;
      err_out       = 1'b0;
      lane          = 2'd0;

      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               byte_count_in = byte_count_ff + 32'd1;
               case (pos) inside
                  [6'd0:6'd1]: begin
                     sig_in[8*pos[0] +: 8] = req_word.data_byte;
                  end
                  [6'd10:6'd13]: begin
                     lane = 2'(pos - 6'd10);
                     offset_in[8*lane +: 8] = req_word.data_byte;
                  end
                  [6'd14:6'd17]: begin
                     lane = 2'(pos - 6'd14);
                     info_in[8*lane +: 8] = req_word.data_byte;
                  end
                  [6'd18:6'd21]: begin
                     lane = 2'(pos - 6'd18);
                     width_raw_in[8*lane +: 8] = req_word.data_byte;
                  end
                  [6'd22:6'd25]: begin
                     lane = 2'(pos - 6'd22);
                     height_raw_in[8*lane +: 8] = req_word.data_byte;
                  end
                  [6'd28:6'd29]: begin
                     bpp_in[8*pos[0] +: 8] = req_word.data_byte;
                  end
                  [6'd30:6'd33]: begin
                     lane = 2'(pos - 6'd30);
                     compress_in[8*lane +: 8] = req_word.data_byte;
                  end
                  default: begin
                  end
               endcase
               if (byte_count_ff == 32'(bmpdec_pkg::HEADER_BYTES - 1)) begin
                  fire = 1'b1;
                  if (check_code != bmpdec_pkg::ERR_NONE) begin
                     out_word.result_kind = bmpdec_pkg::KIND_ERROR;
                     out_word.error_code  = check_code;
                     phase_in = PH_ERROR;
                     err_out  = 1'b1;
                  end else begin
                     out_word.result_kind  = bmpdec_pkg::KIND_HEADER;
                     out_word.image_width  = width_raw_ff[9:0];
                     out_word.image_height = abs_height[9:0];
                     width_in     = width_raw_ff[CW-1:0];
                     height_in    = abs_height[RW-1:0];
                     bottom_up_in = (height_raw_ff != 32'd0) && !height_raw_ff[31];
                     if ((width_raw_ff == 32'd0) || (abs_height == 32'd0)) begin
                        phase_in = PH_DONE;
                     end else if (offset_ff > 32'(bmpdec_pkg::HEADER_BYTES)) begin
                        phase_in = PH_SKIP;
                     end else begin
                        phase_in = PH_PIXELS;
                     end
                  end
               end
            end
            PH_SKIP: begin
               byte_count_in = byte_count_ff + 32'd1;
               if (byte_count_in >= offset_ff) begin
                  phase_in = PH_PIXELS;
               end
            end
            PH_PIXELS: begin
               case (channel_ff)
                  2'd0: begin
                     blue_in    = req_word.data_byte[7:3];
                     channel_in = 2'd1;
                  end
                  2'd1: begin
                     green_in   = req_word.data_byte[7:2];
                     channel_in = 2'd2;
                  end
                  2'd2: begin
                     red_in     = req_word.data_byte[7:3];
                     channel_in = 2'd3;
                  end
                  default: begin
                     channel_in = 2'd0;
                     fire       = 1'b1;
                     out_word.result_kind   = bmpdec_pkg::KIND_PIXEL;
                     out_word.pixel_address = addr_full[17:0];
                     out_word.pixel_value   = {red_ff, green_ff, blue_ff};
                     column_in = column_next[CW-1:0];
                     if (column_next >= {1'b0, width_ff}) begin
                        column_in = '0;
                        row_in    = row_next[RW-1:0];
                        if (row_next >= {1'b0, height_ff}) begin
                           out_word.is_last = 1'b1;
                           phase_in = PH_DONE;
                        end
                     end
                  end
               endcase
            end
            default: begin
            end
         endcase

         if (req_word.end_of_file) begin
            if (!err_out && ((phase_in == PH_HEADER) || (phase_in == PH_SKIP) ||
                             (phase_in == PH_PIXELS))) begin
               fire     = 1'b1;
               out_word = '0;
               out_word.result_kind = bmpdec_pkg::KIND_ERROR;
               out_word.error_code  = bmpdec_pkg::ERR_TRUNCATED;
            end
            phase_in      = PH_HEADER;
            byte_count_in = '0;
            column_in     = '0;
            row_in        = '0;
            channel_in    = 2'd0;
            bottom_up_in  = 1'b0;
         end

         if (fire) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = out_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         byte_count_ff <= '0;
         column_ff     <= '0;
         row_ff        <= '0;
         channel_ff    <= 2'd0;
         bottom_up_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
         channel_ff    <= channel_in;
         bottom_up_ff  <= bottom_up_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sig_ff        <= sig_in;
      bpp_ff        <= bpp_in;
      offset_ff     <= offset_in;
      info_ff       <= info_in;
      width_raw_ff  <= width_raw_in;
      height_raw_ff <= height_raw_in;
      compress_ff   <= compress_in;
      width_ff      <= width_in;
      height_ff     <= height_in;
      blue_ff       <= blue_in;
      green_ff      <= green_in;
      red_ff        <= red_in;
      rsp_word_ff   <= rsp_word_in;
   end

endmodule
